[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the deframer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that cond at one edge implies res at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, res, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (res)) \
		else $error(msg);

`endif

[sv/emcd_pkg.sv]
// ---------------------------------------------------------------------------
// emcd_pkg
// Byte codes of the motor command frame format.
// ---------------------------------------------------------------------------
`default_nettype none

package emcd_pkg;

	localparam logic [7:0] START_BYTE   = 8'd255;
	localparam logic [7:0] CMD_POSITION = 8'd1;
	localparam logic [7:0] CMD_SPEED    = 8'd2;
	localparam logic [7:0] ESC_MAX      = 8'd15;

	localparam logic FRAME_POSITION = 1'b0;
	localparam logic FRAME_SPEED    = 1'b1;

endpackage

`default_nettype wire

[sv/escaped_motor_command_deframer.sv]
// ---------------------------------------------------------------------------
// escaped_motor_command_deframer
// Rebuilds escaped motor command frames from a received byte stream and
// emits the frame kind, the DC and stepper target words and an escape flag.
// ---------------------------------------------------------------------------
//
// channel | handshake            | payload
// --------+----------------------+-------------------------------------------
// input   | in_valid / in_ready  | rx_byte
// output  | out_valid / out_ready| frame_kind, dc_word, stepper_word,
//         |                      | escape_error
//
// One byte is taken per cycle while in_ready is high; the phase register and the data byte
// registers update in the accepting cycle.
// The result of an escape byte shows on the output register the next cycle.
// in_ready drops only while a result waits and out_ready is low.
// Reset puts the deframer idle, waiting for a start byte, output empty.
`default_nettype none
`include "assert_macros.svh"

module escaped_motor_command_deframer
	import emcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             frame_kind,
	output logic [15:0]      dc_word,
	output logic [15:0]      stepper_word,
	output logic             escape_error
);

	typedef enum logic [2:0] {
		PH_CMD     = 3'd0,
		PH_DC_HI   = 3'd1,
		PH_DC_LO   = 3'd2,
		PH_STEP_HI = 3'd3,
		PH_STEP_LO = 3'd4,
		PH_ESC     = 3'd5,
		PH_IDLE    = 3'd6
	} phase_t;

	phase_t      phase_q;
	logic        speed_q;
	logic [7:0]  dc_hi_q;
	logic [7:0]  dc_lo_q;
	logic [7:0]  step_hi_q;
	logic [7:0]  step_lo_q;
	logic        out_valid_q;
	logic        kind_q;
	logic [15:0] dc_word_q;
	logic [15:0] step_word_q;
	logic        err_q;

	logic        in_fire;
	logic        is_start;
	logic        over;
	logic [3:0]  restore;
	logic [7:0]  dc_hi_r;
	logic [7:0]  dc_lo_r;
	logic [7:0]  step_hi_r;
	logic [7:0]  step_lo_r;
	logic        emit;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign is_start = (rx_byte == START_BYTE);

	// An oversized escape restores every data byte.
	assign over    = (rx_byte > ESC_MAX);
	assign restore = over ? 4'hF : rx_byte[3:0];

	assign dc_hi_r   = restore[3] ? START_BYTE : dc_hi_q;
	assign dc_lo_r   = restore[2] ? START_BYTE : dc_lo_q;
	assign step_hi_r = restore[1] ? START_BYTE : step_hi_q;
	assign step_lo_r = restore[0] ? START_BYTE : step_lo_q;

	assign emit = in_fire && !is_start && (phase_q == PH_ESC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			speed_q   <= FRAME_POSITION;
			dc_hi_q   <= '0;
			dc_lo_q   <= '0;
			step_hi_q <= '0;
			step_lo_q <= '0;
		end else if (in_fire) begin
			if (is_start) begin
				phase_q <= PH_CMD;
			end else begin
				unique case (phase_q)
					PH_CMD: begin
						if (rx_byte == CMD_POSITION) begin
							speed_q <= FRAME_POSITION;
							phase_q <= PH_DC_HI;
						end else if (rx_byte == CMD_SPEED) begin
							speed_q <= FRAME_SPEED;
							phase_q <= PH_DC_HI;
						end else begin
							phase_q <= PH_IDLE;
						end
					end
					PH_DC_HI: begin
						dc_hi_q <= rx_byte;
						phase_q <= PH_DC_LO;
					end
					PH_DC_LO: begin
						dc_lo_q <= rx_byte;
						phase_q <= PH_STEP_HI;
					end
					PH_STEP_HI: begin
						step_hi_q <= rx_byte;
						phase_q   <= PH_STEP_LO;
					end
					PH_STEP_LO: begin
						step_lo_q <= rx_byte;
						phase_q   <= PH_ESC;
					end
					PH_ESC: begin
						// keep restored bytes in the data registers
						dc_hi_q   <= dc_hi_r;
						dc_lo_q   <= dc_lo_r;
						step_hi_q <= step_hi_r;
						step_lo_q <= step_lo_r;
						phase_q   <= PH_IDLE;
					end
					default: begin
						phase_q <= PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q      <= speed_q;
			dc_word_q   <= {dc_hi_r, dc_lo_r};
			step_word_q <= {step_hi_r, step_lo_r};
			err_q       <= over;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_kind   = kind_q;
	assign dc_word      = dc_word_q;
	assign stepper_word = step_word_q;
	assign escape_error = err_q;

	`ASSERT_NEXT(a_esc_emits, clk, arst_n, emit, out_valid_q,
		"escape word did not raise out_valid")
	`ASSERT_NEXT(a_start_restarts, clk, arst_n, in_fire && is_start, phase_q == PH_CMD,
		"start word did not restart the frame")
	`ASSERT_CLK(a_err_all_ff, clk, arst_n,
		!(out_valid_q && err_q) || (dc_word_q == 16'hFFFF && step_word_q == 16'hFFFF),
		"escape error without all bytes restored")
	`ASSERT_CLK(a_stall_only_full, clk, arst_n, in_ready || (out_valid_q && !out_ready),
		"input stalled with output free")

endmodule

`default_nettype wire
